### rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the free frame stack allocator: widths,
// input mode codes, internal command codes, result status codes and the
// command word that travels from the front end to the stack engine.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths.
  localparam int FRAME_W    = 20;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int FC_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Command queue between the front end and the stack engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_FRAME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHECK_ENABLE = 2'd2;

  // Configuration reset values.
  localparam logic [FRAME_W-1:0] FIRST_FRAME_RST = 20'd256;
  localparam logic [FC_W-1:0]    FRAME_COUNT_RST = 13'd0;

  // Input mode codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_INIT           = 2'd0,
    MODE_ALLOC          = 2'd1,
    MODE_FREE_CHECKED   = 2'd2,
    MODE_FREE_UNCHECKED = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_DOUBLE = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  // Commands of the stack engine.
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_PUSH  = 2'd2,
    OP_SCAN  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

endpackage

### rtl/ffsa_front.sv
// ----------------------------------------------------------------------------
// ffsa_front
// Accepts words, turns the mode into an engine command and holds the
// commands in a short queue until the stack engine takes them.
// ----------------------------------------------------------------------------
module ffsa_front
  import ffsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [FRAME_W-1:0] in_frame_in,
  input  logic               check_enable,
  output logic               busy,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_pop
);

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  cmd_t              new_cmd;

  // A checked free only scans the stack when checking is switched on.
  always_comb begin
    new_cmd.frame = in_frame_in;
    unique case (mode_t'(in_mode))
      MODE_INIT:         new_cmd.op = OP_INIT;
      MODE_ALLOC:        new_cmd.op = OP_ALLOC;
      MODE_FREE_CHECKED: new_cmd.op = check_enable ? OP_SCAN : OP_PUSH;
      default:           new_cmd.op = OP_PUSH;
    endcase
  end

  assign busy      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !cmd_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (!push && cmd_pop) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/ffsa_back.sv
// ----------------------------------------------------------------------------
// ffsa_back
// Stack engine: owns the frame memory and the stack pointer and carries out
// init fills, pops, pushes and duplicate scans over one memory port.
// ----------------------------------------------------------------------------
module ffsa_back
  import ffsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_pop,
  input  logic [FRAME_W-1:0]  cfg_first_frame,
  input  logic [FC_W-1:0]     cfg_frame_count,
  output logic                out_valid,
  output logic [FRAME_W-1:0]  out_frame_out,
  output logic [STATUS_W-1:0] out_status
);

  localparam int CMP_W = (FC_W > CNT_W) ? FC_W : CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_ALLOC_WAIT,
    S_SCAN
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   top_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   fill_n_r;
  logic [FRAME_W-1:0] fill_val_r;
  logic [FRAME_W-1:0] frame_r;
  logic               rd_valid_r;
  logic [FRAME_W-1:0] rd_data_r;
  logic               out_valid_r;
  logic [FRAME_W-1:0] out_frame_r;
  status_t            out_status_r;

  logic [FRAME_W-1:0] mem [STACK_DEPTH];

  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [FRAME_W-1:0] mem_wdata;

  logic [CNT_W-1:0]   top_m1;
  logic [CNT_W-1:0]   fill_cap;
  logic               stack_empty;
  logic               stack_full;
  logic               scan_issue;
  logic               scan_hit;

  assign top_m1      = top_r - CNT_W'(1);
  assign stack_empty = (top_r == '0);
  assign stack_full  = (top_r == CNT_W'(STACK_DEPTH));
  assign scan_issue  = (idx_r != top_r);
  assign scan_hit    = rd_valid_r && (rd_data_r == frame_r);
  assign fill_cap    = (CMP_W'(cfg_frame_count) > CMP_W'(STACK_DEPTH)) ?
                       CNT_W'(STACK_DEPTH) : CNT_W'(cfg_frame_count);
  assign cmd_pop     = (state_r == S_IDLE) && cmd_valid;

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = top_r[ADDR_W-1:0];
    mem_wdata = cmd.frame;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_ALLOC: begin
              mem_re   = !stack_empty;
              mem_addr = top_m1[ADDR_W-1:0];
            end
            OP_PUSH: begin
              mem_we = !stack_full;
            end
            OP_SCAN: begin
              mem_we = stack_empty;
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = idx_r[ADDR_W-1:0];
        mem_wdata = fill_val_r;
      end
      S_SCAN: begin
        mem_wdata = frame_r;
        if (scan_issue) begin
          mem_re   = 1'b1;
          mem_addr = idx_r[ADDR_W-1:0];
        end else begin
          mem_we = rd_valid_r && !scan_hit && !stack_full;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_valid_r  <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            out_frame_r  <= '0;
            out_status_r <= STAT_OK;
            unique case (cmd.op)
              OP_INIT: begin
                idx_r      <= '0;
                fill_n_r   <= fill_cap;
                fill_val_r <= cfg_first_frame;
                if (fill_cap == '0) begin
                  top_r       <= '0;
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_FILL;
                end
              end
              OP_ALLOC: begin
                if (stack_empty) begin
                  out_status_r <= STAT_EMPTY;
                  out_valid_r  <= 1'b1;
                end else begin
                  top_r   <= top_m1;
                  state_r <= S_ALLOC_WAIT;
                end
              end
              OP_PUSH: begin
                out_valid_r <= 1'b1;
                if (stack_full) begin
                  out_status_r <= STAT_FULL;
                end else begin
                  top_r <= top_r + CNT_W'(1);
                end
              end
              default: begin
                // Scan; an empty stack cannot hold a duplicate.
                if (stack_empty) begin
                  top_r       <= top_r + CNT_W'(1);
                  out_valid_r <= 1'b1;
                end else begin
                  frame_r <= cmd.frame;
                  idx_r   <= '0;
                  state_r <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          idx_r      <= idx_r + CNT_W'(1);
          fill_val_r <= fill_val_r + FRAME_W'(1);
          if (idx_r == fill_n_r - CNT_W'(1)) begin
            top_r       <= fill_n_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_ALLOC_WAIT: begin
          out_frame_r <= rd_data_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          // Reads are issued one per cycle and each is compared in the cycle after it is issued.
          if (scan_hit) begin
            out_status_r <= STAT_DOUBLE;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end else if (scan_issue) begin
            idx_r      <= idx_r + CNT_W'(1);
            rd_valid_r <= 1'b1;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (stack_full) begin
              out_status_r <= STAT_FULL;
            end else begin
              top_r <= top_r + CNT_W'(1);
            end
          end
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_frame_out = out_frame_r;
  assign out_status    = out_status_r;

endmodule

### rtl/free_frame_stack_allocator.sv
// ----------------------------------------------------------------------------
// free_frame_stack_allocator
// Page-frame allocator that keeps free frame numbers on a last-in first-out
// stack held in a single-port memory.
// ----------------------------------------------------------------------------
// A word is taken at a clock edge where start is high and busy is low; every
// word produces exactly one result, shown for one cycle with out_valid high,
// and the receiver cannot stall it, so it must take each result as it comes.
// Up to two words wait in a command queue while the stack engine works, and
// busy rises only when that queue is full. A free without a check, and an
// alloc that finds the stack empty, finish in the idle state; an alloc that
// finds a frame reads the memory, then passes on the registered data; an init
// writes the n frames that it pushes one after another; a checked free reads
// the stacked frames once before it pushes and stops early on a duplicate. A
// checked free on an empty stack, or with checking off, is handled like an
// unchecked free. All of these steps share the single memory port. Each result
// is registered before it leaves. The frame memory needs no clearing after
// reset: only entries below the stack pointer are ever read, and each of them
// has been written.
// Configuration writes are meant for idle periods only, since queued words
// use the first-frame and frame-count values in force when carried out.
// ----------------------------------------------------------------------------
module free_frame_stack_allocator
  import ffsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Command channel.
  input  logic                  start,
  output logic                  busy,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [FRAME_W-1:0]    in_frame_in,
  // Result channel.
  output logic                  out_valid,
  output logic [FRAME_W-1:0]    out_frame_out,
  output logic [STATUS_W-1:0]   out_status,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FRAME_W-1:0] first_frame_r;
  logic [FC_W-1:0]    frame_count_r;
  logic               check_enable_r;

  logic               cmd_valid;
  logic               cmd_pop;
  cmd_t               cmd;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_frame_r  <= FIRST_FRAME_RST;
      frame_count_r  <= FRAME_COUNT_RST;
      check_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_FIRST_FRAME:  first_frame_r  <= cfg_data[FRAME_W-1:0];
        CFG_IDX_FRAME_COUNT:  frame_count_r  <= cfg_data[FC_W-1:0];
        CFG_IDX_CHECK_ENABLE: check_enable_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each word and queues it as a command.
  ffsa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_mode      (in_mode),
    .in_frame_in  (in_frame_in),
    .check_enable (check_enable_r),
    .busy         (busy),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // The stack engine carries out one command at a time.
  ffsa_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .cfg_first_frame (first_frame_r),
    .cfg_frame_count (frame_count_r),
    .out_valid       (out_valid),
    .out_frame_out   (out_frame_out),
    .out_status      (out_status)
  );

endmodule

### rtl/ffsa_checker.sv
// ----------------------------------------------------------------------------
// ffsa_assert
// Port-level checks of the free frame stack allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffsa_assert
  import ffsa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [MODE_W-1:0]   in_mode,
  input logic                out_valid,
  input logic [FRAME_W-1:0]  out_frame_out,
  input logic [STATUS_W-1:0] out_status
);

  // Reset leaves no result pending and the queue open.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy seen right after reset");

  // Only a successful alloc carries a frame number.
  a_fail_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_frame_out == '0)
    else $error("failed result carries a nonzero frame");

  // An alloc straight out of reset finds the stack empty.
  a_alloc_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) == 1'b0 && start && !busy && in_mode == MODE_ALLOC
    |=> ##1 out_valid && out_status == STAT_EMPTY)
    else $error("alloc after reset not reported empty");

  // A free straight out of reset is pushed.
  a_free_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) == 1'b0 && start && !busy &&
    (in_mode == MODE_FREE_CHECKED || in_mode == MODE_FREE_UNCHECKED)
    |=> ##1 out_valid && out_status == STAT_OK && out_frame_out == '0)
    else $error("free after reset not accepted");

endmodule

bind free_frame_stack_allocator ffsa_assert u_ffsa_assert (.*);
